### rtl/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// Shared widths, codes and the front-to-back command type for the expander.
// ----------------------------------------------------------------------------
package gse_pkg;

    localparam int MAX_STEPS_DEF = 63;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 24;
    localparam int RATIO_W       = 16;
    localparam int IDX_W         = 6;
    localparam int ST_W          = 3;
    localparam int TAIL_W        = 40;

    typedef enum logic [1:0] {
        MODE_GREEDY = 2'd0,
        MODE_LAZY   = 2'd1,
        MODE_GAPS   = 2'd2,
        MODE_GAPS3  = 2'd3
    } t_mode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO_PRC = 3'd1,
        ST_LOW_Q    = 3'd2,
        ST_REACH    = 3'd3,
        ST_GAP      = 3'd4,
        ST_STEPS    = 3'd5,
        ST_RSV6     = 3'd6,
        ST_RSV7     = 3'd7
    } t_status;

    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_RATIO     = 2'd1;
    localparam logic [1:0] CFG_PRECISION = 2'd2;

    // Command passed from the front (checks, divisions) to the back (loop).
    typedef struct packed {
        logic              reject;
        t_status           status;
        logic              lazy;
        logic              gaps;
        logic [VAL_W-1:0]  target;
        logic [VAL_W-1:0]  prec;
        logic [RATIO_W-1:0] q;
        logic [TAIL_W-1:0] tail;
    } t_cmd;

endpackage

### rtl/gse_front.sv
// ----------------------------------------------------------------------------
// gse_front
// Accepts targets, runs the range checks and a restoring division for the reach
// (also the tail outside lazy mode), a second one for the lazy tail, and issues a command.
// ----------------------------------------------------------------------------
module gse_front #(
    parameter int FRAC_BITS = gse_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gse_pkg::VAL_W-1:0]    i_target,
    input  logic [1:0]                   i_mode,
    input  logic [gse_pkg::RATIO_W-1:0]  i_ratio,
    input  logic [gse_pkg::VAL_W-1:0]    i_prec,
    output logic                         o_cmd_valid,
    input  logic                         i_cmd_stall,
    output gse_pkg::t_cmd                o_cmd
);

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int DW    = 2 * FRAC_BITS;          // dividend width
    localparam int CW    = $clog2(DW + 1);
    localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} t_state;

    t_state             r_state;
    logic [DW-1:0]      r_quo;
    logic [ONE_W:0]     r_rem;
    logic [ONE_W-1:0]   r_den;
    logic [CW-1:0]      r_cnt;
    logic               r_pass;      // 0 reach, 1 lazy tail
    gse_pkg::t_cmd      r_cmd;

    logic [ONE_W-1:0]   w_q;
    logic [ONE_W:0]     w_sh;
    logic               w_ge;
    logic [DW-1:0]      w_qnext;

    assign w_q = (i_ratio >= ONE[gse_pkg::RATIO_W-1:0] && FRAC_BITS < gse_pkg::RATIO_W)
               ? ONE - ONE_W'(1) : ONE_W'(i_ratio);
    assign w_sh = {r_rem[ONE_W-1:0], r_quo[DW-1]};
    assign w_ge = w_sh >= {1'b0, r_den};
    assign w_qnext = {r_quo[DW-2:0], w_ge};

    assign o_stall     = (r_state != S_IDLE);
    assign o_cmd_valid = (r_state == S_OUT);
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd.target <= i_target;
                        r_cmd.prec   <= i_prec;
                        r_cmd.q      <= gse_pkg::RATIO_W'(w_q);
                        r_cmd.lazy   <= (i_mode == gse_pkg::MODE_LAZY);
                        r_cmd.gaps   <= i_mode[1];
                        r_cmd.tail   <= '0;
                        r_pass       <= 1'b0;
                        if (i_prec == '0) begin
                            r_cmd.reject <= 1'b1;
                            r_cmd.status <= gse_pkg::ST_ZERO_PRC;
                            r_state      <= S_OUT;
                        end else if (!i_mode[1] && w_q != '0 && !w_q[FRAC_BITS-1]) begin
                            r_cmd.reject <= 1'b1;
                            r_cmd.status <= gse_pkg::ST_LOW_Q;
                            r_state      <= S_OUT;
                        end else begin
                            r_cmd.reject <= 1'b0;
                            r_cmd.status <= gse_pkg::ST_OK;
                            r_quo        <= DW'(w_q) << FRAC_BITS;
                            r_rem        <= '0;
                            r_den        <= ONE - w_q;
                            r_cnt        <= '0;
                            r_state      <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // One quotient bit per cycle.
                    if (r_cnt != CW'(DW - 1)) begin
                        r_quo <= w_qnext;
                        r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                        r_cnt <= r_cnt + CW'(1);
                    end else if (!r_pass) begin
                        if (w_qnext < DW'(r_cmd.target)) begin
                            r_cmd.reject <= 1'b1;
                            r_cmd.status <= gse_pkg::ST_REACH;
                            r_state      <= S_OUT;
                        end else if (r_cmd.lazy) begin
                            r_pass <= 1'b1;
                            r_quo  <= DW'(r_cmd.q) * DW'(r_cmd.q);
                            r_rem  <= '0;
                            r_cnt  <= '0;
                        end else begin
                            r_cmd.tail <= gse_pkg::TAIL_W'(w_qnext);
                            r_state    <= S_OUT;
                        end
                    end else begin
                        r_cmd.tail <= gse_pkg::TAIL_W'(w_qnext);
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_cmd_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/gse_queue.sv
// ----------------------------------------------------------------------------
// gse_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module gse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gse_pkg::t_cmd i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output gse_pkg::t_cmd o_data
);

    gse_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### rtl/gse_back.sv
// ----------------------------------------------------------------------------
// gse_back
// Runs the term loop for one command and emits term and summary items.
// ----------------------------------------------------------------------------
module gse_back #(
    parameter int MAX_STEPS = gse_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = gse_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_stall,
    input  gse_pkg::t_cmd                 i_cmd,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_summary,
    output logic [gse_pkg::IDX_W-1:0]     o_term_index,
    output logic [gse_pkg::VAL_W-1:0]     o_approx_sum,
    output logic [gse_pkg::ST_W-1:0]      o_last_status,
    output logic                          o_last
);

    localparam int TW = gse_pkg::TAIL_W;
    localparam int RW = gse_pkg::RATIO_W;
    localparam logic [TW-1:0] TAIL_CAP = TW'(1) << (TW - 1);

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_MUL, S_OUT} t_state;

    t_state                     r_state;
    gse_pkg::t_cmd              r_cmd;
    logic [gse_pkg::VAL_W-1:0]  r_rem;
    logic [RW-1:0]              r_term;
    logic [TW-1:0]              r_tail;
    logic [gse_pkg::IDX_W:0]    r_idx;
    logic                       r_done;
    logic [RW+RW-1:0]           r_pterm;
    logic [TW+RW-1:0]           r_ptail;
    logic                       r_ov;
    logic                       r_is_sum;
    logic [gse_pkg::IDX_W-1:0]  r_oidx;
    logic [gse_pkg::VAL_W-1:0]  r_osum;
    logic [gse_pkg::ST_W-1:0]   r_ost;

    logic w_cont, w_take, w_tail_gt;
    logic [TW+RW-1:0] w_tshift;

    assign w_tail_gt = r_tail > TW'(r_rem);
    assign w_cont = (r_rem > r_cmd.prec) && (!r_cmd.gaps || w_tail_gt);
    assign w_take = (r_term != '0) &&
                    (r_cmd.lazy ? (TW'(r_rem) > r_tail) : (r_rem > gse_pkg::VAL_W'(r_term)));
    assign w_tshift = r_ptail >> FRAC_BITS;

    assign o_cmd_stall   = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_is_summary  = r_is_sum;
    assign o_term_index  = r_oidx;
    assign o_approx_sum  = r_osum;
    assign o_last_status = r_ost;
    assign o_last        = r_is_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_rem  <= i_cmd.target;
                        r_term <= i_cmd.q;
                        r_tail <= (i_cmd.tail > TAIL_CAP) ? TAIL_CAP : i_cmd.tail;
                        r_idx  <= (gse_pkg::IDX_W+1)'(1);
                        r_done <= i_cmd.reject;
                        if (i_cmd.reject) begin
                            r_is_sum <= 1'b1;
                            r_oidx   <= '0;
                            r_osum   <= '0;
                            r_ost    <= i_cmd.status;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (!w_cont || r_idx > (gse_pkg::IDX_W+1)'(MAX_STEPS)) begin
                        r_is_sum <= 1'b1;
                        r_oidx   <= '0;
                        r_osum   <= r_cmd.target - r_rem;
                        if (w_cont)
                            r_ost <= gse_pkg::ST_STEPS;
                        else if (r_cmd.gaps && !w_tail_gt)
                            r_ost <= gse_pkg::ST_GAP;
                        else
                            r_ost <= gse_pkg::ST_OK;
                        r_done  <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_pterm <= r_term * r_cmd.q;
                        r_ptail <= r_tail * r_cmd.q;
                        r_ov    <= w_take;
                        if (w_take) begin
                            r_rem <= (r_rem > gse_pkg::VAL_W'(r_term))
                                   ? r_rem - gse_pkg::VAL_W'(r_term) : '0;
                            r_is_sum <= 1'b0;
                            r_oidx   <= r_idx[gse_pkg::IDX_W-1:0];
                            r_osum   <= '0;
                            r_ost    <= gse_pkg::ST_OK;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_term <= RW'(r_pterm >> FRAC_BITS);
                    r_tail <= (w_tshift > (TW+RW)'(TAIL_CAP)) ? TAIL_CAP : TW'(w_tshift);
                    r_idx  <= r_idx + (gse_pkg::IDX_W+1)'(1);
                    r_state <= r_ov ? S_OUT : S_STEP;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= r_done ? S_IDLE : S_STEP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/geometric_subseries_expansion.sv
// ----------------------------------------------------------------------------
// geometric_subseries_expansion
// Expands a Q8.16 target as a subseries of q, q^2, q^3, ... in greedy, lazy
// or gap-detecting mode, emitting each chosen index and a closing summary.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_target_value
//  output  | out       | o_valid / i_stall  | o_is_summary, o_term_index,
//          |           |                    | o_approx_sum, o_status, o_last
//  config  | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// Work: the front runs the reach division for each target and, in lazy mode,
// a second division for the lazy tail, one quotient bit per cycle. The back
// visits each index with a compare step and a multiply step and emits each
// chosen term and a closing summary, for at most MAX_STEPS indices per target.
// The two-entry command queue lets the front divide the next target while
// the back iterates. Reset is synchronous and active low and clears control
// state and the registers to mode 0, ratio 49152, precision 1. A stalled
// result holds the back only; the front keeps working until the queue fills.
module geometric_subseries_expansion #(
    parameter int MAX_STEPS = gse_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = gse_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gse_pkg::VAL_W-1:0]    i_target_value,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [gse_pkg::VAL_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_is_summary,
    output logic [gse_pkg::IDX_W-1:0]    o_term_index,
    output logic [gse_pkg::VAL_W-1:0]    o_approx_sum,
    output logic [gse_pkg::ST_W-1:0]     o_status,
    output logic                         o_last
);

    // Configuration registers.
    logic [1:0]                  r_mode;
    logic [gse_pkg::RATIO_W-1:0] r_ratio;
    logic [gse_pkg::VAL_W-1:0]   r_prec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= gse_pkg::MODE_GREEDY;
            r_ratio <= gse_pkg::RATIO_W'(49152);
            r_prec  <= gse_pkg::VAL_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gse_pkg::CFG_MODE:      r_mode  <= i_cfg_data[1:0];
                gse_pkg::CFG_RATIO:     r_ratio <= i_cfg_data[gse_pkg::RATIO_W-1:0];
                gse_pkg::CFG_PRECISION: r_prec  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gse_pkg::t_cmd w_fcmd, w_bcmd;
    logic w_fvalid, w_fstall, w_bvalid, w_bstall;

    gse_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_target    (i_target_value),
        .i_mode      (r_mode),
        .i_ratio     (r_ratio),
        .i_prec      (r_prec),
        .o_cmd_valid (w_fvalid),
        .i_cmd_stall (w_fstall),
        .o_cmd       (w_fcmd)
    );

    gse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fvalid),
        .o_stall (w_fstall),
        .i_data  (w_fcmd),
        .o_valid (w_bvalid),
        .i_stall (w_bstall),
        .o_data  (w_bcmd)
    );

    gse_back #(.MAX_STEPS(MAX_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_bvalid),
        .o_cmd_stall   (w_bstall),
        .i_cmd         (w_bcmd),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_is_summary  (o_is_summary),
        .o_term_index  (o_term_index),
        .o_approx_sum  (o_approx_sum),
        .o_last_status (o_status),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // A term item never carries a status or the last flag.
    a_term_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_summary) |-> (o_status == gse_pkg::ST_OK && !o_last))
        else $error("term item with status or last");
    // Term items always name a power of at least one.
    a_term_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_summary) |-> (o_term_index != '0))
        else $error("term index zero");
    // Rejected runs report a zero sum.
    a_reject_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == gse_pkg::ST_ZERO_PRC || o_status == gse_pkg::ST_LOW_Q
                     || o_status == gse_pkg::ST_REACH)) |-> (o_approx_sum == '0))
        else $error("rejected run with nonzero sum");
`endif

endmodule
